// File: hdl/fesd_pkg.sv
// ----------------------------------------------------------------------------
// fesd_pkg
// shared types and constants of the flight end stationarity detector
// ----------------------------------------------------------------------------
package fesd_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(HIST_DEPTH);

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int ALT_W  = 18;
    localparam int HSP_W  = 13;
    localparam int VSP_W  = 15;
    localparam int VLIM_W = 10;
    localparam int CFG_W  = 29;
    localparam int CIDX_W = 3;

    // squared distance in microdegrees beyond which the pilot is far
    localparam int FAR_LIMIT_SQ = 12957926;
    // largest axis offset whose square can stay within the far limit
    localparam int FAR_AXIS_MAX = 3599;
    localparam int ALT_HIGH     = 30;
    localparam int ALT_GATE     = 50;
    localparam int ALT_DEV_LIM  = 30 * HIST_DEPTH * HIST_DEPTH;
    // smallest deviation sum in microdegrees that fails the horizontal test
    localparam int XY_DEV_LIM   = (3000000 * HIST_DEPTH - 1) / 11112 + 1;

    localparam int SQ_OP_W    = 13;
    localparam int SQ_W       = 2 * SQ_OP_W;
    localparam int ROOT_STEPS = SQ_OP_W;
    localparam int RCNT_W     = 4;

    localparam int SA_W   = ALT_W + IDX_W;
    localparam int SX_W   = LON_W + IDX_W;
    localparam int SY_W   = LAT_W + IDX_W;
    localparam int DALT_W = SA_W + 1;
    localparam int DEVA_W = DALT_W + IDX_W;
    localparam int DEVX_W = SQ_OP_W + IDX_W;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_QUERY   = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TAKEOFF_LAT = 3'd0,
        CFG_TAKEOFF_LON = 3'd1,
        CFG_TAKEOFF_ALT = 3'd2,
        CFG_VERT_LIMIT  = 3'd3,
        CFG_HORIZ_LIMIT = 3'd4
    } cfg_idx_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOCK_A = 8'b0000_0010,
        S_LOCK_B = 8'b0000_0100,
        S_SUM    = 8'b0000_1000,
        S_DEV_X  = 8'b0001_0000,
        S_DEV_Y  = 8'b0010_0000,
        S_ROOT   = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

endpackage

// File: hdl/flight_end_stationarity_detector_top.sv
// ----------------------------------------------------------------------------
// flight_end_stationarity_detector_top
// ring of recent fixes with lock latch and flight end query
// ----------------------------------------------------------------------------
// One item at a time. A push passes through the two lock states; a restart,
// an unknown request and a query that fails the full-ring or altitude gate go
// straight to finish; a full query makes one sum pass over the ring, then per
// entry two passes through the shared squaring multiplier and a 13-step
// bit-per-cycle square root. The input is stalled from transfer until the
// result is loaded into the output register.
module flight_end_stationarity_detector_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fesd_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [fesd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic signed [fesd_pkg::LAT_W-1:0] cur_lat,
    input  logic signed [fesd_pkg::LON_W-1:0] cur_lon,
    input  logic signed [fesd_pkg::ALT_W-1:0] cur_alt,
    input  logic [fesd_pkg::HSP_W-1:0]    horiz_speed,
    input  logic signed [fesd_pkg::VSP_W-1:0] vert_speed,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          flight_ended,
    output logic                          flight_locked,
    output logic                          history_full
);
    import fesd_pkg::*;

    logic signed [LAT_W-1:0]  takeoff_lat_reg;
    logic signed [LON_W-1:0]  takeoff_lon_reg;
    logic signed [ALT_W-1:0]  takeoff_alt_reg;
    logic [VLIM_W-1:0]        vert_limit_reg;
    logic [HSP_W-1:0]         horiz_limit_reg;

    logic signed [LAT_W-1:0]  ring_lat [HIST_DEPTH];
    logic signed [LON_W-1:0]  ring_lon [HIST_DEPTH];
    logic signed [ALT_W-1:0]  ring_alt [HIST_DEPTH];
    logic [HSP_W-1:0]         ring_hspeed [HIST_DEPTH];
    logic signed [VSP_W-1:0]  ring_vspeed [HIST_DEPTH];

    state_t                   state_reg;
    logic [IDX_W-1:0]         widx_reg;
    logic                     wrapped_reg;
    logic                     far_seen_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [RCNT_W-1:0]        rcnt_reg;

    logic signed [LAT_W-1:0]  lat_reg;
    logic signed [LON_W-1:0]  lon_reg;
    logic signed [ALT_W-1:0]  alt_reg;
    logic [HSP_W-1:0]         hs_reg;

    logic signed [SA_W-1:0]   sa_reg;
    logic signed [SX_W-1:0]   sx_reg;
    logic signed [SY_W-1:0]   sy_reg;
    logic [DEVA_W-1:0]        dev_alt_reg;
    logic [DEVX_W-1:0]        dev_xy_reg;
    logic                     calm_reg;
    logic                     xy_fail_reg;
    logic [SQ_W-1:0]          acc_reg;
    logic [SQ_W-1:0]          root_reg;
    logic [SQ_W-1:0]          bit_reg;
    logic                     ended_reg;

    logic                     out_valid_reg;
    logic                     flight_ended_reg;
    logic                     flight_locked_reg;
    logic                     history_full_reg;

    logic                     accept;
    logic                     out_free;

    // lock datapath
    logic signed [LAT_W:0]    dlat_s;
    logic signed [LON_W:0]    dlon_s;
    logic signed [ALT_W:0]    dalt_s;
    logic signed [ALT_W:0]    gate_s;
    logic [LAT_W:0]           dlat_m;
    logic [LON_W:0]           dlon_m;
    logic [ALT_W:0]           dalt_m;
    logic                     axis_far;

    // deviation datapath
    logic signed [LON_W-1:0]  cx;
    logic signed [LAT_W-1:0]  cy;
    logic signed [LON_W:0]    dx_s;
    logic signed [LAT_W:0]    dy_s;
    logic [LON_W:0]           dx_m;
    logic [LAT_W:0]           dy_m;
    logic signed [SA_W-1:0]   alt_scaled;
    logic signed [DALT_W-1:0] da_s;
    logic [DALT_W-1:0]        da_m;
    logic [VSP_W-1:0]         vs_m;

    // shared squaring unit and root step
    logic [SQ_OP_W-1:0]       mul_op;
    logic [SQ_W-1:0]          mul_prod;
    logic [SQ_W-1:0]          sq_sum;
    logic [SQ_W-1:0]          trial;
    logic                     take;
    logic [SQ_W-1:0]          root_next;
    logic [DEVX_W-1:0]        dev_xy_next;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign flight_ended  = flight_ended_reg;
    assign flight_locked = flight_locked_reg;
    assign history_full  = history_full_reg;

    always_comb
    begin
        dlat_s = {lat_reg[LAT_W-1], lat_reg} - {takeoff_lat_reg[LAT_W-1], takeoff_lat_reg};
        dlon_s = {lon_reg[LON_W-1], lon_reg} - {takeoff_lon_reg[LON_W-1], takeoff_lon_reg};
        dalt_s = {alt_reg[ALT_W-1], alt_reg} - {takeoff_alt_reg[ALT_W-1], takeoff_alt_reg};
        gate_s = {cur_alt[ALT_W-1], cur_alt} - {takeoff_alt_reg[ALT_W-1], takeoff_alt_reg};
        dlat_m = dlat_s[LAT_W] ? (LAT_W+1)'(1'b0) - dlat_s : dlat_s;
        dlon_m = dlon_s[LON_W] ? (LON_W+1)'(1'b0) - dlon_s : dlon_s;
        dalt_m = dalt_s[ALT_W] ? (ALT_W+1)'(1'b0) - dalt_s : dalt_s;
        axis_far = (dlat_m > (LAT_W+1)'(FAR_AXIS_MAX)) || (dlon_m > (LON_W+1)'(FAR_AXIS_MAX));

        cx   = LON_W'(sx_reg >>> IDX_W);
        cy   = LAT_W'(sy_reg >>> IDX_W);
        dx_s = {cx[LON_W-1], cx} - {ring_lon[idx_reg][LON_W-1], ring_lon[idx_reg]};
        dy_s = {cy[LAT_W-1], cy} - {ring_lat[idx_reg][LAT_W-1], ring_lat[idx_reg]};
        dx_m = dx_s[LON_W] ? (LON_W+1)'(1'b0) - dx_s : dx_s;
        dy_m = dy_s[LAT_W] ? (LAT_W+1)'(1'b0) - dy_s : dy_s;
        alt_scaled = SA_W'(ring_alt[idx_reg]) <<< IDX_W;
        da_s = {sa_reg[SA_W-1], sa_reg} - {alt_scaled[SA_W-1], alt_scaled};
        da_m = da_s[DALT_W-1] ? DALT_W'(1'b0) - da_s : da_s;
        vs_m = ring_vspeed[idx_reg][VSP_W-1] ? VSP_W'(1'b0) - ring_vspeed[idx_reg]
                                             : ring_vspeed[idx_reg];

        case (state_reg)
            S_LOCK_A: mul_op = dlat_m[SQ_OP_W-1:0];
            S_LOCK_B: mul_op = dlon_m[SQ_OP_W-1:0];
            S_DEV_X:  mul_op = dx_m[SQ_OP_W-1:0];
            S_DEV_Y:  mul_op = dy_m[SQ_OP_W-1:0];
            default:  mul_op = '0;
        endcase
        mul_prod = mul_op * mul_op;
        sq_sum   = acc_reg + mul_prod;

        trial       = root_reg + bit_reg;
        take        = (acc_reg >= trial);
        root_next   = take ? (root_reg >> 1) + bit_reg : (root_reg >> 1);
        dev_xy_next = dev_xy_reg + DEVX_W'(root_next[SQ_OP_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            takeoff_lat_reg <= '0;
            takeoff_lon_reg <= '0;
            takeoff_alt_reg <= '0;
            vert_limit_reg  <= VLIM_W'(50);
            horiz_limit_reg <= HSP_W'(50);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TAKEOFF_LAT: takeoff_lat_reg <= cfg_data[LAT_W-1:0];
                CFG_TAKEOFF_LON: takeoff_lon_reg <= cfg_data[LON_W-1:0];
                CFG_TAKEOFF_ALT: takeoff_alt_reg <= cfg_data[ALT_W-1:0];
                CFG_VERT_LIMIT:  vert_limit_reg  <= cfg_data[VLIM_W-1:0];
                CFG_HORIZ_LIMIT: horiz_limit_reg <= cfg_data[HSP_W-1:0];
                default: ;
            endcase
        end
    end

    // ring storage, no reset
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_PUSH)
        begin
            ring_lat[widx_reg]    <= cur_lat;
            ring_lon[widx_reg]    <= cur_lon;
            ring_alt[widx_reg]    <= cur_alt;
            ring_hspeed[widx_reg] <= horiz_speed;
            ring_vspeed[widx_reg] <= vert_speed;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                lat_reg     <= cur_lat;
                lon_reg     <= cur_lon;
                alt_reg     <= cur_alt;
                hs_reg      <= horiz_speed;
                sa_reg      <= '0;
                sx_reg      <= '0;
                sy_reg      <= '0;
                dev_alt_reg <= '0;
                dev_xy_reg  <= '0;
                calm_reg    <= 1'b1;
                xy_fail_reg <= 1'b0;
                ended_reg   <= 1'b0;
            end
            S_LOCK_A: acc_reg <= mul_prod;
            S_SUM:
            begin
                sa_reg <= sa_reg + SA_W'(ring_alt[idx_reg]);
                sx_reg <= sx_reg + SX_W'(ring_lon[idx_reg]);
                sy_reg <= sy_reg + SY_W'(ring_lat[idx_reg]);
                if (ring_hspeed[idx_reg] > horiz_limit_reg
                    || vs_m > VSP_W'(vert_limit_reg))
                begin
                    calm_reg <= 1'b0;
                end
            end
            S_DEV_X:
            begin
                acc_reg     <= mul_prod;
                dev_alt_reg <= dev_alt_reg + DEVA_W'(da_m);
                if (dx_m >= (LON_W+1)'(XY_DEV_LIM) || dy_m >= (LAT_W+1)'(XY_DEV_LIM))
                begin
                    xy_fail_reg <= 1'b1;
                end
            end
            S_DEV_Y:
            begin
                acc_reg  <= sq_sum;
                root_reg <= '0;
                bit_reg  <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
            end
            S_ROOT:
            begin
                if (take)
                begin
                    acc_reg <= acc_reg - trial;
                end
                root_reg <= root_next;
                bit_reg  <= bit_reg >> 2;
                if (rcnt_reg == RCNT_W'(ROOT_STEPS - 1))
                begin
                    dev_xy_reg <= dev_xy_next;
                    ended_reg  <= calm_reg && !xy_fail_reg
                                  && dev_alt_reg < DEVA_W'(ALT_DEV_LIM)
                                  && dev_xy_next < DEVX_W'(XY_DEV_LIM);
                end
            end
            default: ;
        endcase
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            widx_reg      <= '0;
            wrapped_reg   <= 1'b0;
            far_seen_reg  <= 1'b0;
            idx_reg       <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (accept)
                    begin
                        case (req_type)
                            REQ_PUSH:
                            begin
                                if (widx_reg == IDX_W'(HIST_DEPTH - 1))
                                begin
                                    widx_reg    <= '0;
                                    wrapped_reg <= 1'b1;
                                end
                                else
                                begin
                                    widx_reg <= widx_reg + 1'b1;
                                end
                                state_reg <= S_LOCK_A;
                            end
                            REQ_QUERY:
                            begin
                                if (wrapped_reg && gate_s <= (ALT_W+1)'(ALT_GATE))
                                begin
                                    state_reg <= S_SUM;
                                end
                                else
                                begin
                                    state_reg <= S_FINISH;
                                end
                            end
                            REQ_RESTART:
                            begin
                                widx_reg     <= '0;
                                wrapped_reg  <= 1'b0;
                                far_seen_reg <= 1'b0;
                                state_reg    <= S_FINISH;
                            end
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_LOCK_A: state_reg <= S_LOCK_B;
                S_LOCK_B:
                begin
                    if (axis_far || sq_sum > SQ_W'(FAR_LIMIT_SQ)
                        || dalt_m > (ALT_W+1)'(ALT_HIGH))
                    begin
                        far_seen_reg <= 1'b1;
                    end
                    state_reg <= S_FINISH;
                end
                S_SUM:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(HIST_DEPTH - 1))
                    begin
                        state_reg <= S_DEV_X;
                    end
                end
                S_DEV_X: state_reg <= S_DEV_Y;
                S_DEV_Y:
                begin
                    rcnt_reg  <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    rcnt_reg <= rcnt_reg + 1'b1;
                    if (rcnt_reg == RCNT_W'(ROOT_STEPS - 1))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == IDX_W'(HIST_DEPTH - 1))
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_DEV_X;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && out_free)
        begin
            flight_ended_reg  <= ended_reg;
            flight_locked_reg <= far_seen_reg || (hs_reg > horiz_limit_reg);
            history_full_reg  <= wrapped_reg;
        end
    end

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("transfer did not start work");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result loaded outside finish");

    a_ended_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && flight_ended_reg |-> history_full_reg)
        else $error("flight end reported with ring not full");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT |-> rcnt_reg < RCNT_W'(ROOT_STEPS))
        else $error("root step count overrun");

endmodule
